FILE: rtl/ite_pkg.sv
package ite_pkg;

	// String layout
	localparam logic [4:0] TS_LEN = 5'd19;

	// Default depth of the queue between parser and arithmetic
	localparam int Q_DEPTH = 2;

	// Characters of interest
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// Calendar arithmetic
	localparam logic [14:0] YEAR_BIAS    = 15'd10000;   // 25 eras, keeps the year positive
	localparam logic signed [6:0] ERA_BIAS = 7'sd25;
	localparam logic signed [23:0] ERA_DAYS = 24'sd146097;
	localparam logic signed [23:0] EPOCH_SHIFT = 24'sd719468;
	localparam logic signed [17:0] DAY_SECS = 18'sd86400;
	localparam logic signed [19:0] HOUR_SECS = 20'sd3600;
	localparam logic signed [19:0] MIN_SECS = 20'sd60;
	localparam logic signed [16:0] WD_BIAS = 17'sd14006;  // 2000 weeks plus Monday shift
	localparam logic [30:0] RECIP7 = 31'd37450;           // ceil(2^18 / 7)

	typedef enum logic [2:0] {
		FLD_YEAR,
		FLD_MONTH,
		FLD_DAY,
		FLD_HOUR,
		FLD_MINUTE,
		FLD_SECOND
	} ite_field_t;

	typedef struct packed {
		logic       in_field;
		logic       first;
		logic       stop;
		ite_field_t fld;
	} ite_pos_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last;
	} ite_in_t;

	typedef struct packed {
		logic               valid_res;
		logic signed [39:0] epoch_seconds;
		logic        [2:0]  weekday;
		logic signed [7:0]  hour_of_day;
	} ite_out_t;

	// One parsed string, handed from parser to arithmetic
	typedef struct packed {
		logic               ok;
		logic signed [14:0] year;
		logic signed [7:0]  month;
		logic signed [7:0]  day;
		logic signed [7:0]  hour;
		logic signed [7:0]  minute;
		logic signed [7:0]  second;
	} ite_rec_t;

	function automatic ite_pos_t pos_decode(input logic [4:0] pos);
		ite_pos_t d;
		d = '{in_field: 1'b1, first: 1'b0, stop: 1'b0, fld: FLD_YEAR};
		case (pos)
			5'd0:  begin d.fld = FLD_YEAR;   d.first = 1'b1; end
			5'd1:  d.fld = FLD_YEAR;
			5'd2:  d.fld = FLD_YEAR;
			5'd3:  begin d.fld = FLD_YEAR;   d.stop = 1'b1; end
			5'd5:  begin d.fld = FLD_MONTH;  d.first = 1'b1; end
			5'd6:  begin d.fld = FLD_MONTH;  d.stop = 1'b1; end
			5'd8:  begin d.fld = FLD_DAY;    d.first = 1'b1; end
			5'd9:  begin d.fld = FLD_DAY;    d.stop = 1'b1; end
			5'd11: begin d.fld = FLD_HOUR;   d.first = 1'b1; end
			5'd12: begin d.fld = FLD_HOUR;   d.stop = 1'b1; end
			5'd14: begin d.fld = FLD_MINUTE; d.first = 1'b1; end
			5'd15: begin d.fld = FLD_MINUTE; d.stop = 1'b1; end
			5'd17: begin d.fld = FLD_SECOND; d.first = 1'b1; end
			5'd18: begin d.fld = FLD_SECOND; d.stop = 1'b1; end
			default: d.in_field = 1'b0;
		endcase
		return d;
	endfunction

	// Days from 1 March to the first of the month: (153*mp+2)/5
	function automatic logic [8:0] doy_base(input logic [3:0] mo);
		logic [8:0] r;
		case (mo)
			4'd3:  r = 9'd0;
			4'd4:  r = 9'd31;
			4'd5:  r = 9'd61;
			4'd6:  r = 9'd92;
			4'd7:  r = 9'd122;
			4'd8:  r = 9'd153;
			4'd9:  r = 9'd184;
			4'd10: r = 9'd214;
			4'd11: r = 9'd245;
			4'd12: r = 9'd275;
			4'd1:  r = 9'd306;
			4'd2:  r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Month offsets for the weekday sum
	function automatic logic [2:0] sak_offset(input logic [3:0] mo);
		logic [2:0] r;
		case (mo)
			4'd1:  r = 3'd0;
			4'd2:  r = 3'd3;
			4'd3:  r = 3'd2;
			4'd4:  r = 3'd5;
			4'd5:  r = 3'd0;
			4'd6:  r = 3'd3;
			4'd7:  r = 3'd5;
			4'd8:  r = 3'd1;
			4'd9:  r = 3'd4;
			4'd10: r = 3'd6;
			4'd11: r = 3'd2;
			4'd12: r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// floor(x/25) for x < 4096, reciprocal 1311/2^15
	function automatic logic [7:0] div25(input logic [11:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd1311;
		return p[22:15];
	endfunction

endpackage

FILE: rtl/ite_queue.sv
module ite_queue #(
	parameter int Depth = ite_pkg::Q_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ite_pkg::ite_rec_t wdata,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output ite_pkg::ite_rec_t rdata
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	ite_pkg::ite_rec_t mem_q [Depth];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(Depth));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop && !empty) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/ite_front.sv
module ite_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  ite_pkg::ite_in_t  byte_data,
	output logic              push,
	output ite_pkg::ite_rec_t rec
);

	ite_pkg::ite_pos_t dec;

	logic [4:0]  pos_q, pos_n;
	logic [14:0] acc_q, acc_n;
	logic        neg_q, neg_n;
	logic        fail_q, fail_n;
	logic signed [14:0] year_q, year_n;
	logic signed [7:0]  mon_q, mon_n, day_q, day_n, hr_q, hr_n, min_q, min_n, sec_q, sec_n;

	logic        is_digit, is_sign;
	logic [3:0]  dval;
	logic [14:0] val;
	logic        mon_ok;

	assign dec      = ite_pkg::pos_decode(pos_q);
	assign is_digit = (byte_data.text_byte >= ite_pkg::CH_ZERO) &&
	                  (byte_data.text_byte <= ite_pkg::CH_NINE);
	assign is_sign  = (byte_data.text_byte == ite_pkg::CH_PLUS) ||
	                  (byte_data.text_byte == ite_pkg::CH_MINUS);
	assign dval     = 4'(byte_data.text_byte - ite_pkg::CH_ZERO);

	always_comb begin
		acc_n  = acc_q;
		neg_n  = neg_q;
		fail_n = fail_q;
		year_n = year_q;
		mon_n  = mon_q;
		day_n  = day_q;
		hr_n   = hr_q;
		min_n  = min_q;
		sec_n  = sec_q;
		if (dec.in_field) begin
			if (dec.first) begin
				acc_n = is_digit ? 15'(dval) : '0;
				neg_n = (byte_data.text_byte == ite_pkg::CH_MINUS);
				if (!is_digit && !is_sign) begin
					fail_n = 1'b1;
				end
			end else if (is_digit) begin
				acc_n = acc_q * 15'd10 + 15'(dval);
			end else begin
				fail_n = 1'b1;
			end
		end
		val = neg_n ? -acc_n : acc_n;
		if (dec.in_field && dec.stop) begin
			case (dec.fld)
				ite_pkg::FLD_YEAR:   year_n = $signed(val);
				ite_pkg::FLD_MONTH:  mon_n  = $signed(val[7:0]);
				ite_pkg::FLD_DAY:    day_n  = $signed(val[7:0]);
				ite_pkg::FLD_HOUR:   hr_n   = $signed(val[7:0]);
				ite_pkg::FLD_MINUTE: min_n  = $signed(val[7:0]);
				ite_pkg::FLD_SECOND: sec_n  = $signed(val[7:0]);
				default:             year_n = year_q;
			endcase
		end
		pos_n = (pos_q == ite_pkg::TS_LEN) ? pos_q : pos_q + 5'd1;
	end

	assign mon_ok = (mon_n >= 8'sd1) && (mon_n <= 8'sd12);

	assign push       = accept && byte_data.last;
	assign rec.ok     = !fail_n && (pos_n == ite_pkg::TS_LEN) && mon_ok;
	assign rec.year   = year_n;
	assign rec.month  = mon_n;
	assign rec.day    = day_n;
	assign rec.hour   = hr_n;
	assign rec.minute = min_n;
	assign rec.second = sec_n;

	// field registers are rewritten before any valid string reads them
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q  <= acc_n;
			neg_q  <= neg_n;
			year_q <= year_n;
			mon_q  <= mon_n;
			day_q  <= day_n;
			hr_q   <= hr_n;
			min_q  <= min_n;
			sec_q  <= sec_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fail_q <= 1'b0;
		end else if (accept) begin
			if (byte_data.last) begin
				pos_q  <= '0;
				fail_q <= 1'b0;
			end else begin
				pos_q  <= pos_n;
				fail_q <= fail_n;
			end
		end
	end

endmodule

FILE: rtl/ite_back.sv
module ite_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  ite_pkg::ite_rec_t q_head,
	output logic              q_pop,
	output logic              res_valid,
	input  logic              res_stall,
	output ite_pkg::ite_out_t res_data
);

	logic adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, out_vld_q;
	ite_pkg::ite_out_t out_q;

	// carried from stage to stage until used
	logic        ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6;
	logic signed [7:0] hh_s1, hh_s2, hh_s3, hh_s4, hh_s5, hh_s6;
	logic signed [7:0] mi_s1, mi_s2, mi_s3, mi_s4;
	logic signed [7:0] ss_s1, ss_s2, ss_s3, ss_s4;
	logic signed [7:0] dy_s1, dy_s2, dy_s3;
	logic [8:0]  doyb_s1, doyb_s2, doyb_s3;
	logic [2:0]  sak_s1, sak_s2;

	// stage 1: shifted year, biased and absolute forms
	logic signed [14:0] y1, ny1;
	logic signed [14:0] y_s1, y_s2;
	logic [14:0] u_s1, u_s2;
	logic [13:0] ay1, ay_s1;

	// stage 2: divisions by 400 and 100
	logic [7:0]  era_off_s2, d100_s2, d400_s2;
	logic [11:0] d4_s2;

	// stage 3
	logic [14:0] eo400, yoe_w;
	logic [8:0]  yoe_s3;
	logic signed [6:0] era_s3, era_s4;
	logic signed [16:0] m17, tw;
	logic [14:0] wx_s3, wx_s4;

	// stage 4
	logic [17:0] y365;
	logic [1:0]  c100;
	logic signed [18:0] doe_s4;
	logic [30:0] wp;
	logic [12:0] wq_s4;

	// stage 5
	logic signed [23:0] days_s5;
	logic [14:0] w7, wr;
	logic [2:0]  wd_s5, wd_s6;
	logic signed [19:0] part_s5;

	// stage 6
	logic signed [41:0] dprod;
	logic signed [39:0] secs_s6;

	assign adv       = !out_vld_q || !res_stall;
	assign q_pop     = adv && !q_empty;
	assign res_valid = out_vld_q;
	assign res_data  = out_q;

	assign y1  = q_head.year - (($signed(q_head.month) <= 8'sd2) ? 15'sd1 : 15'sd0);
	assign ny1 = -y1;
	assign ay1 = y1[14] ? ny1[13:0] : y1[13:0];

	assign eo400  = 15'(era_off_s2) * 15'd400;
	assign yoe_w  = u_s2 - eo400;
	// trunc(y/4) - trunc(y/100) + trunc(y/400) = sign(y) * m17
	assign m17    = $signed({5'b0, d4_s2}) - $signed({9'b0, d100_s2}) + $signed({9'b0, d400_s2});
	assign tw     = 17'(y_s2) + (y_s2[14] ? -m17 : m17) + $signed({14'b0, sak_s2})
	              + 17'(dy_s2) + ite_pkg::WD_BIAS;

	assign y365 = 18'(yoe_s3) * 18'd365;
	assign c100 = 2'((yoe_s3 >= 9'd100) ? 1 : 0) + 2'((yoe_s3 >= 9'd200) ? 1 : 0)
	            + 2'((yoe_s3 >= 9'd300) ? 1 : 0);
	assign wp   = 31'(wx_s3) * ite_pkg::RECIP7;

	assign w7 = 15'(wq_s4) * 15'd7;
	assign wr = wx_s4 - w7;

	assign dprod = days_s5 * ite_pkg::DAY_SECS;

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			ok_s1   <= q_head.ok;
			y_s1    <= y1;
			u_s1    <= $unsigned(y1) + ite_pkg::YEAR_BIAS;
			ay_s1   <= ay1;
			doyb_s1 <= ite_pkg::doy_base(q_head.month[3:0]);
			sak_s1  <= ite_pkg::sak_offset(q_head.month[3:0]);
			dy_s1   <= q_head.day;
			hh_s1   <= q_head.hour;
			mi_s1   <= q_head.minute;
			ss_s1   <= q_head.second;
			// stage 2
			ok_s2      <= ok_s1;
			y_s2       <= y_s1;
			u_s2       <= u_s1;
			era_off_s2 <= ite_pkg::div25({1'b0, u_s1[14:4]});
			d100_s2    <= ite_pkg::div25(ay_s1[13:2]);
			d400_s2    <= ite_pkg::div25({2'b0, ay_s1[13:4]});
			d4_s2      <= ay_s1[13:2];
			doyb_s2    <= doyb_s1;
			sak_s2     <= sak_s1;
			dy_s2      <= dy_s1;
			hh_s2      <= hh_s1;
			mi_s2      <= mi_s1;
			ss_s2      <= ss_s1;
			// stage 3
			ok_s3   <= ok_s2;
			yoe_s3  <= yoe_w[8:0];
			era_s3  <= $signed({1'b0, era_off_s2[5:0]}) - ite_pkg::ERA_BIAS;
			wx_s3   <= tw[14:0];
			doyb_s3 <= doyb_s2;
			dy_s3   <= dy_s2;
			hh_s3   <= hh_s2;
			mi_s3   <= mi_s2;
			ss_s3   <= ss_s2;
			// stage 4
			ok_s4  <= ok_s3;
			doe_s4 <= $signed({1'b0, y365}) + $signed({12'b0, yoe_s3[8:2]})
			        - $signed({17'b0, c100}) + $signed({10'b0, doyb_s3})
			        + 19'(dy_s3) - 19'sd1;
			wq_s4  <= wp[30:18];
			wx_s4  <= wx_s3;
			era_s4 <= era_s3;
			hh_s4  <= hh_s3;
			mi_s4  <= mi_s3;
			ss_s4  <= ss_s3;
			// stage 5
			ok_s5   <= ok_s4;
			days_s5 <= 24'(era_s4) * ite_pkg::ERA_DAYS + 24'(doe_s4) - ite_pkg::EPOCH_SHIFT;
			wd_s5   <= wr[2:0];
			part_s5 <= 20'(hh_s4) * ite_pkg::HOUR_SECS + 20'(mi_s4) * ite_pkg::MIN_SECS
			         + 20'(ss_s4);
			hh_s5   <= hh_s4;
			// stage 6
			ok_s6   <= ok_s5;
			secs_s6 <= dprod[39:0] + 40'(part_s5);
			wd_s6   <= wd_s5;
			hh_s6   <= hh_s5;
			// result register
			out_q.valid_res     <= ok_s6;
			out_q.epoch_seconds <= ok_s6 ? secs_s6 : '0;
			out_q.weekday       <= ok_s6 ? wd_s6 : '0;
			out_q.hour_of_day   <= ok_s6 ? hh_s6 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= !q_empty;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			out_vld_q <= vld_s6;
		end
	end

endmodule

FILE: rtl/iso_timestamp_to_epoch_weekday.sv
// Channel   Dir  Handshake               Payload
// byte      in   byte_valid/byte_stall   ite_in_t  (text_byte, last)
// res       out  res_valid/res_stall     ite_out_t (valid_res, epoch_seconds, weekday,
//                                                   hour_of_day)
//
// One byte beat is taken per cycle while the queue is not full; the parser keeps up
// with the stream at full rate. A result beat passes the queue write, six arithmetic
// stages and the result register; the pipeline accepts one string a cycle unless res_stall holds it.
// arst_n clears the byte position, error flag, queue and stage valid bits only.
// byte_stall rises only while the parser-to-arithmetic queue is full; res_stall freezes
// the whole arithmetic pipeline while a result beat is presented, and the pipeline then backs up into the queue.
module iso_timestamp_to_epoch_weekday #(
	parameter int QDepth = ite_pkg::Q_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  ite_pkg::ite_in_t  byte_data,
	output logic              res_valid,
	input  logic              res_stall,
	output ite_pkg::ite_out_t res_data
);

	logic              q_full;
	logic              q_empty;
	logic              q_push;
	logic              q_pop;
	ite_pkg::ite_rec_t q_wdata;
	ite_pkg::ite_rec_t q_head;

	// Only the last byte of a string pushes, but holding the whole channel while the
	// queue is full keeps the stall independent of the payload.
	assign byte_stall = q_full;

	// Parser: position counter, per-field decimal accumulation and sign, error flag.
	// Bytes at separator offsets and beyond offset 18 are ignored.
	ite_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (byte_valid && !q_full),
		.byte_data (byte_data),
		.push      (q_push),
		.rec       (q_wdata)
	);

	// Short queue of parsed strings so parser and arithmetic stall independently.
	ite_queue #(
		.Depth (QDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_head)
	);

	// Arithmetic: days from civil with floored era, weekday sum mod 7, seconds assembly.
	// Invalid strings pass through and come out as an all-zero beat with valid_res low.
	ite_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
